// ----- rtl/edit_distance_engine_macros.svh -----
// Assertion helpers for the edit distance engine.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// cons must hold in the same cycle as ante
`define EDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ede_pkg.sv -----
package ede_pkg;

  // action codes
  localparam logic [1:0] ACT_SRC     = 2'd0;
  localparam logic [1:0] ACT_TGT     = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [6:0] SKIP_VALUE = 7'd100;
  localparam logic [6:0] GAP_RESET  = 7'd5;
  localparam logic [6:0] DIST_MAX   = 7'd127;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INIT    = 6'b000010,
    ST_ROW     = 6'b000100,
    ST_CELL_RD = 6'b001000,
    ST_CELL_WR = 6'b010000,
    ST_DONE    = 6'b100000
  } ede_state_e;

endpackage

// ----- rtl/edit_distance_engine.sv -----
// A skipped compute (gap over the limit) strobes its result in the cycle right after the
// transfer. Otherwise the table walk runs row-zero init, then per row one source fetch plus a
// read state and a write state per cell, then a report state; an empty source goes straight to
// the report state and an empty target skips the init. Throughput: one append per cycle while
// busy_o is low; busy_o is high for the whole table walk. Reset: async active low; lengths,
// dropped flag, sequencer cleared, gap limit back to 5. Receiver cannot stall.
`include "edit_distance_engine_macros.svh"

module edit_distance_engine
  import ede_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command channel
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] char_value_i,
  // gap limit register
  input  logic       gap_limit_we_i,
  input  logic [6:0] gap_limit_i,
  // result channel
  output logic       done_o,
  output logic [6:0] distance_o,
  output logic       skipped_o,
  output logic       overflow_o
);

  // LenW holds 0..MAX_LEN; IdxW addresses MAX_LEN entries.
  localparam int LenW = $clog2(MAX_LEN + 1);
  localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // common width for comparing lengths/costs against 7-bit quantities
  localparam int CmpW = (LenW > 7) ? LenW : 7;

  // ---------------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------------
  ede_state_e      state_q, state_d;
  logic [LenW-1:0] src_len_q, src_len_d;
  logic [LenW-1:0] tgt_len_q, tgt_len_d;
  logic            dropped_q, dropped_d;
  logic [6:0]      gap_limit_q;

  // row / column counters, both run from 1
  logic [LenW-1:0] i_q, i_d;
  logic [LenW-1:0] j_q, j_d;
  // DP registers: diag = previous row at j-1, left = current row at j-1
  logic [LenW-1:0] diag_q, diag_d;
  logic [LenW-1:0] left_q, left_d;

  logic            done_q, done_d;
  logic [6:0]      dist_q, dist_d;
  logic            skip_q, skip_d;
  logic            ovf_q, ovf_d;

  // Memories: character stores and one row of the cost table. Cost row entry j lives at
  // address j-1; column 0 is never stored since it is just the row number.
  logic [7:0]      src_mem [MAX_LEN];
  logic [7:0]      tgt_mem [MAX_LEN];
  logic [LenW-1:0] cost_mem [MAX_LEN];
  logic [7:0]      src_rd_q;
  logic [7:0]      tgt_rd_q;
  logic [LenW-1:0] cost_rd_q;

  // ---------------------------------------------------------------------------------------
  // Handshake decode
  // ---------------------------------------------------------------------------------------
  logic accept;
  logic src_full, tgt_full;
  logic src_wr, tgt_wr;
  assign accept   = start_i && (state_q == ST_IDLE);
  assign src_full = (src_len_q == LenW'(MAX_LEN));
  assign tgt_full = (tgt_len_q == LenW'(MAX_LEN));
  assign src_wr   = accept && (action_i == ACT_SRC) && !src_full;
  assign tgt_wr   = accept && (action_i == ACT_TGT) && !tgt_full;

  // length gap check: absolute difference, then compare
  logic [LenW-1:0] gap;
  logic            gap_too_big;
  assign gap         = (src_len_q >= tgt_len_q) ? (src_len_q - tgt_len_q)
                                                : (tgt_len_q - src_len_q);
  assign gap_too_big = CmpW'(gap) > CmpW'(gap_limit_q);

  // ---------------------------------------------------------------------------------------
  // Shared cell unit: compare chars, 3-way min, increment
  // ---------------------------------------------------------------------------------------
  logic [LenW-1:0] min_al, min3, cell_cost;
  assign min_al    = (cost_rd_q < left_q) ? cost_rd_q : left_q;
  assign min3      = (min_al < diag_q) ? min_al : diag_q;
  assign cell_cost = (src_rd_q == tgt_rd_q) ? diag_q : (min3 + 1'b1);

  // final distance, saturated to 7 bits
  logic [CmpW-1:0] left_ext;
  logic [6:0]      left_sat;
  assign left_ext = CmpW'(left_q);
  assign left_sat = (left_ext > CmpW'(DIST_MAX)) ? DIST_MAX : left_ext[6:0];

  logic cost_we;
  logic [IdxW-1:0] cost_addr;
  logic [LenW-1:0] cost_wdata;
  assign cost_we    = (state_q == ST_INIT) || (state_q == ST_CELL_WR);
  assign cost_addr  = IdxW'(j_q - 1'b1);
  assign cost_wdata = (state_q == ST_INIT) ? j_q : cell_cost;

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    src_len_d = src_len_q;
    tgt_len_d = tgt_len_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    diag_d    = diag_q;
    left_d    = left_q;
    done_d    = 1'b0;
    dist_d    = dist_q;
    skip_d    = skip_q;
    ovf_d     = ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_SRC: begin
              if (src_full) begin
                dropped_d = 1'b1;
              end else begin
                src_len_d = src_len_q + 1'b1;
              end
            end
            ACT_TGT: begin
              if (tgt_full) begin
                dropped_d = 1'b1;
              end else begin
                tgt_len_d = tgt_len_q + 1'b1;
              end
            end
            ACT_COMPUTE: begin
              if (gap_too_big) begin
                // no table walk: report right away and clear
                done_d    = 1'b1;
                dist_d    = SKIP_VALUE;
                skip_d    = 1'b1;
                ovf_d     = dropped_q;
                src_len_d = '0;
                tgt_len_d = '0;
                dropped_d = 1'b0;
              end else if (src_len_q == '0) begin
                // empty source: distance is the target length
                left_d  = tgt_len_q;
                state_d = ST_DONE;
              end else if (tgt_len_q == '0) begin
                i_d     = LenW'(1);
                state_d = ST_ROW;
              end else begin
                j_d     = LenW'(1);
                state_d = ST_INIT;
              end
            end
            default: begin
              // unused action: transfer taken, nothing happens
            end
          endcase
        end
      end

      ST_INIT: begin
        // row zero: cost[j] = j
        if (j_q == tgt_len_q) begin
          i_d     = LenW'(1);
          state_d = ST_ROW;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      ST_ROW: begin
        // source char fetched here, held for the whole row
        diag_d = i_q - 1'b1;
        left_d = i_q;
        j_d    = LenW'(1);
        if (tgt_len_q == '0) begin
          if (i_q == src_len_q) begin
            state_d = ST_DONE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          state_d = ST_CELL_RD;
        end
      end

      ST_CELL_RD: begin
        state_d = ST_CELL_WR;
      end

      ST_CELL_WR: begin
        left_d = cell_cost;
        diag_d = cost_rd_q;
        if (j_q == tgt_len_q) begin
          if (i_q == src_len_q) begin
            state_d = ST_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_ROW;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_CELL_RD;
        end
      end

      ST_DONE: begin
        done_d    = 1'b1;
        dist_d    = left_sat;
        skip_d    = 1'b0;
        ovf_d     = dropped_q;
        src_len_d = '0;
        tgt_len_d = '0;
        dropped_d = 1'b0;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_len_q   <= '0;
      tgt_len_q   <= '0;
      dropped_q   <= 1'b0;
      gap_limit_q <= GAP_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      src_len_q <= src_len_d;
      tgt_len_q <= tgt_len_d;
      dropped_q <= dropped_d;
      done_q    <= done_d;
      if (gap_limit_we_i) begin
        gap_limit_q <= gap_limit_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    diag_q <= diag_d;
    left_q <= left_d;
    dist_q <= dist_d;
    skip_q <= skip_d;
    ovf_q  <= ovf_d;
  end

  // ---------------------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (src_wr) begin
      src_mem[IdxW'(src_len_q)] <= char_value_i;
    end
    if (state_q == ST_ROW) begin
      src_rd_q <= src_mem[IdxW'(i_q - 1'b1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tgt_wr) begin
      tgt_mem[IdxW'(tgt_len_q)] <= char_value_i;
    end
    if (state_q == ST_CELL_RD) begin
      tgt_rd_q <= tgt_mem[cost_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_addr] <= cost_wdata;
    end
    if (state_q == ST_CELL_RD) begin
      cost_rd_q <= cost_mem[cost_addr];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------------------
  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign distance_o = dist_q;
  assign skipped_o  = skip_q;
  assign overflow_o = ovf_q;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `EDE_ASSERT_SAME(a_skip_value, done_o && skipped_o, distance_o == SKIP_VALUE,
                   "skipped result must carry the fixed distance")
  `EDE_ASSERT_SAME(a_cleared_on_result, done_o,
                   (src_len_q == '0) && (tgt_len_q == '0) && !dropped_q,
                   "strings not cleared when result is strobed")
  `EDE_ASSERT_SAME(a_col_range, state_q == ST_CELL_WR,
                   (j_q != '0) && (j_q <= tgt_len_q),
                   "column counter outside target length")
  `EDE_ASSERT_SAME(a_row_range, state_q == ST_ROW,
                   (i_q != '0) && (i_q <= src_len_q),
                   "row counter outside source length")
  `EDE_ASSERT_NEXT(a_done_strobe, state_q == ST_DONE, done_o && !skipped_o && !busy_o,
                   "table walk did not end in a result strobe")

endmodule
